### rtl/pds_pkg.sv
// Package with shared widths and the sequencer state type for the divisor-sum block.
`default_nettype none

package pds_pkg;

  // Width of the number port and of the divisor-sum result port.
  localparam int unsigned NumberPortWidth = 32;
  localparam int unsigned SumWidth        = 36;

  // One-hot states of the trial-division sequencer.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_CHECK = 7'b0001000,
    ST_ADDD  = 7'b0010000,
    ST_ADDQ  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } pds_state_e;

endpackage

`default_nettype wire

### rtl/proper_divisor_sum.sv
// Top level: aliquot sum and perfect-number flag by trial division.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+-----------------------------
//   input   | in_valid_i / in_stall_o   | number_i
//   output  | out_valid_o / out_stall_i | divisor_sum_o, is_perfect_o
//
// W is the used number width. An input n above one runs floor(sqrt(n)) trial divisors.
// Each trial loads the divider, runs W quotient steps and a done step, then tests the bound
// and the remainder. A divisor found is added in ST_ADDD, and its cofactor in ST_ADDQ when
// it differs. Inputs 0 and 1 skip the trials and go straight to the done state, which moves
// the sum into the output register. Reset is asynchronous, active low.
// A new transaction is taken only while the sequencer is idle; a finished result waits in
// the output register while the next item is worked on, and a stalled full output register
// holds the sequencer in its done state.
`default_nettype none

module proper_divisor_sum
  import pds_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [NumberPortWidth-1:0] number_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [SumWidth-1:0]             divisor_sum_o,
  output logic                            is_perfect_o
);

  // Only the low bits of the port that fit both the port and the parameter are used.
  localparam int unsigned NW = (NUMBER_WIDTH > NumberPortWidth) ? NumberPortWidth
                                                                 : NUMBER_WIDTH;

  pds_state_e          state_q, state_d;
  logic [NW-1:0]       n_q, n_d;
  logic [NW-1:0]       d_q, d_d;
  logic [SumWidth-1:0] sum_q, sum_d;
  logic                out_valid_q;
  logic [SumWidth-1:0] out_sum_q;
  logic                out_perf_q;

  logic                div_start;
  logic                div_done;
  logic [NW-1:0]       quo;
  logic [NW-1:0]       rem;
  logic [NW-1:0]       addend;
  logic [SumWidth-1:0] acc_sum;
  logic                in_accept;
  logic                out_free;
  logic                perfect;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign div_start = (state_q == ST_LOAD);

  // Shared divider: n divided by the current trial divisor.
  pds_div #(
    .Width (NW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (n_q),
    .divisor_i   (d_q),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // Single accumulator adder, fed with either the divisor or its cofactor.
  assign addend  = (state_q == ST_ADDQ) ? quo : d_q;
  assign acc_sum = sum_q + {{(SumWidth - NW){1'b0}}, addend};

  // The flag needs n above one and a sum equal to n.
  assign perfect = (sum_q == {{(SumWidth - NW){1'b0}}, n_q}) && (|n_q[NW-1:1]);

  // Sequencer: load, divide, test the bound, accumulate, next divisor.
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    d_d     = d_q;
    sum_d   = sum_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          n_d = number_i[NW-1:0];
          d_d = NW'(2);
          if (|number_i[NW-1:1]) begin
            sum_d   = SumWidth'(1);
            state_d = ST_LOAD;
          end else begin
            sum_d   = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_LOAD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (d_q > quo) begin
          state_d = ST_DONE;
        end else if (rem == '0) begin
          state_d = ST_ADDD;
        end else begin
          d_d     = d_q + NW'(1);
          state_d = ST_LOAD;
        end
      end
      ST_ADDD: begin
        sum_d = acc_sum;
        if (quo != d_q) begin
          state_d = ST_ADDQ;
        end else begin
          d_d     = d_q + NW'(1);
          state_d = ST_LOAD;
        end
      end
      ST_ADDQ: begin
        sum_d   = acc_sum;
        d_d     = d_q + NW'(1);
        state_d = ST_LOAD;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    sum_q <= sum_d;
  end

  // Output register: filled when the item is finished and the slot is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_sum_q  <= sum_q;
      out_perf_q <= perfect;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign divisor_sum_o = out_sum_q;
  assign is_perfect_o  = out_perf_q;

endmodule

`default_nettype wire

### rtl/pds_div.sv
// Iterative restoring divider that produces one quotient bit per cycle.
`default_nettype none

module pds_div #(
  parameter int unsigned Width = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic                  done_o,
  output logic [Width-1:0]      quotient_o,
  output logic [Width-1:0]      remainder_o
);

  localparam int unsigned CntWidth = $clog2(Width + 1);

  logic                busy_q;
  logic                done_q;
  logic [CntWidth-1:0] cnt_q;
  logic [Width-1:0]    rem_q;
  logic [Width-1:0]    quo_q;
  logic [Width-1:0]    div_q;
  logic [Width:0]      rem_sh;
  logic [Width:0]      diff;
  logic                fits;

  // Shift the next dividend bit into the partial remainder and trial-subtract.
  assign rem_sh = {rem_q, quo_q[Width-1]};
  assign diff   = rem_sh - {1'b0, div_q};
  assign fits   = (rem_sh >= {1'b0, div_q});

  // Control: count Width steps, then pulse done for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntWidth'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(Width);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntWidth'(1);
        if (cnt_q == CntWidth'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: remainder, quotient and a held copy of the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[Width-1:0] : rem_sh[Width-1:0];
      quo_q <= {quo_q[Width-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

### bench/tb_proper_divisor_sum.sv
// Self-checking testbench for the aliquot-sum block, with a scoreboard class and random idling.
`default_nettype none

module tb_proper_divisor_sum
  import pds_pkg::*;
();

  // Number width used by the block instance below; the predictor masks to it.
  localparam int unsigned NumberWidth = 32;
  // Generous cycle ceiling, several times the slowest legal run.
  localparam longint unsigned RunLimit = 64'd20_000_000;
  localparam int unsigned RandomItems = 100;

  // Expected-result store and aliquot-sum predictor.
  class aliquot_scoreboard;
    typedef struct {
      logic [SumWidth-1:0] divisor_sum;
      logic                is_perfect;
    } aliquot_result_t;

    aliquot_result_t pending_results[$];
    int unsigned     error_count;

    function new();
      error_count = 0;
    endfunction

    // Works out the aliquot sum of an accepted number and queues the result.
    function void note_number(logic [NumberPortWidth-1:0] raw);
      longint unsigned n;
      longint unsigned total;
      longint unsigned d;
      longint unsigned co;
      aliquot_result_t expected;
      n = longint'(raw) & ((64'd1 << NumberWidth) - 64'd1);
      total = 0;
      if (n > 1) begin
        total = 1;
        for (d = 2; d <= n / d; d++) begin
          if (n % d == 0) begin
            co = n / d;
            total += d;
            // The root of a perfect square is counted only once.
            if (co != d) begin
              total += co;
            end
          end
        end
      end
      expected.divisor_sum = total[SumWidth-1:0];
      expected.is_perfect  = (n > 1) && (total == n);
      pending_results.push_back(expected);
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(logic [SumWidth-1:0] sum, logic perfect);
      aliquot_result_t expected;
      if (pending_results.size() == 0) begin
        $error("unexpected result: divisor_sum %0d, is_perfect %0b", sum, perfect);
        error_count++;
        return;
      end
      expected = pending_results.pop_front();
      if (sum !== expected.divisor_sum) begin
        $error("divisor_sum: expected %0d, actual %0d", expected.divisor_sum, sum);
        error_count++;
      end
      if (perfect !== expected.is_perfect) begin
        $error("is_perfect: expected %0b, actual %0b", expected.is_perfect, perfect);
        error_count++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid;
  logic                       in_stall;
  logic [NumberPortWidth-1:0] number;
  logic                       out_valid;
  logic                       out_stall;
  logic [SumWidth-1:0]        divisor_sum;
  logic                       is_perfect;

  aliquot_scoreboard board = new();
  // When set, both sides run without idling.
  bit                no_idle;
  longint unsigned   cycle_count = 0;

  proper_divisor_sum #(
    .NUMBER_WIDTH(NumberWidth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .number_i     (number),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .divisor_sum_o(divisor_sum),
    .is_perfect_o (is_perfect)
  );

  // Free-running clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RunLimit) begin
      $display("proper_divisor_sum regression: fail");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Random numbers: mostly small ones, so the trial division stays short.
  function automatic logic [NumberPortWidth-1:0] pick_number(int unsigned idx);
    int unsigned span;
    int unsigned root;
    if (idx % 33 == 0) begin
      span = 24;
    end else if (idx % 8 == 0) begin
      span = 20;
    end else begin
      span = 16;
    end
    case ($urandom_range(0, 9))
      0: return NumberPortWidth'($urandom_range(0, 1));
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'd6;
          1: return 32'd28;
          2: return 32'd496;
          default: return 32'd8128;
        endcase
      end
      2, 3: begin
        root = $urandom_range(2, (1 << (span / 2)) - 1);
        return NumberPortWidth'(root * root);
      end
      4: return NumberPortWidth'(1) << $urandom_range(0, span - 1);
      default: return $urandom & ((32'd1 << span) - 1);
    endcase
  endfunction

  // Offers one number after a random gap and waits until it is taken.
  task automatic send_number(logic [NumberPortWidth-1:0] n);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    number   <= n;
    do @(posedge clk_i); while (in_stall);
    board.note_number(n);
  endtask

  // Result receiver: stalls for a random number of cycles before each transaction.
  initial begin
    int unsigned gap;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
      end
      @(negedge clk_i);
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      board.check_result(divisor_sum, is_perfect);
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [NumberPortWidth-1:0] directed_numbers[$];
    no_idle     = 1'b0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    number      = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero and one, small primes and squares, perfect numbers and the extremes.
    directed_numbers = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd9, 32'd12, 32'd36,
                         32'd6, 32'd28, 32'd496, 32'd8128, 32'd1024, 32'd65521,
                         32'd65536, 32'd33550336, 32'hFFFF_FFFF, 32'd1, 32'd0};
    foreach (directed_numbers[i]) begin
      send_number(directed_numbers[i]);
    end

    for (int unsigned i = 0; i < RandomItems; i++) begin
      // Runs of ten items switch between idling and full-rate traffic.
      if (i % 10 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_number(pick_number(i));
    end
    @(negedge clk_i);
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (board.outstanding() != 0) begin
      @(posedge clk_i);
    end
    repeat (64) @(posedge clk_i);

    if (board.error_count == 0) begin
      $display("proper_divisor_sum regression: pass");
    end else begin
      $display("proper_divisor_sum regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
